// File: rtl/mdc_pkg.sv
// Package for the key driven dual motor duty control.
// Holds key codes, configuration register indexes and the decoded command type.
// No dependencies.
package mdc_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COARSE = 3'd0,
    CFG_STEP_FINE   = 3'd1,
    CFG_STEP_BRAKE  = 3'd2,
    CFG_DUTY_MIN    = 3'd3,
    CFG_DUTY_MAX    = 3'd4
  } mdc_cfg_idx_t;

  localparam logic [7:0] KEY_TAB       = 8'd9;
  localparam logic [7:0] KEY_ESC       = 8'd27;
  localparam logic [7:0] KEY_SPACE     = 8'd32;
  localparam logic [7:0] KEY_COMMA     = 8'd44;
  localparam logic [7:0] KEY_PERIOD    = 8'd46;
  localparam logic [7:0] KEY_3         = 8'd51;
  localparam logic [7:0] KEY_4         = 8'd52;
  localparam logic [7:0] KEY_ARROW_UP  = 8'd65;
  localparam logic [7:0] KEY_ARROW_DN  = 8'd66;
  localparam logic [7:0] KEY_ARROW_RT  = 8'd67;
  localparam logic [7:0] KEY_ARROW_LT  = 8'd68;
  localparam logic [7:0] KEY_BRACKET   = 8'd91;
  localparam logic [7:0] KEY_BACKTICK  = 8'd96;
  localparam logic [7:0] KEY_C         = 8'd99;
  localparam logic [7:0] KEY_D         = 8'd100;
  localparam logic [7:0] KEY_E         = 8'd101;
  localparam logic [7:0] KEY_F         = 8'd102;
  localparam logic [7:0] KEY_G         = 8'd103;
  localparam logic [7:0] KEY_R         = 8'd114;
  localparam logic [7:0] KEY_S         = 8'd115;
  localparam logic [7:0] KEY_T         = 8'd116;
  localparam logic [7:0] KEY_V         = 8'd118;
  localparam logic [7:0] KEY_W         = 8'd119;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_HALT,
    OP_TOGGLE,
    OP_SET_MAX,
    OP_ADD_COARSE,
    OP_SUB_COARSE,
    OP_SET_MIN,
    OP_SET_FWD,
    OP_SET_REV,
    OP_DYN_FWD,
    OP_DYN_REV,
    OP_ACCEL,
    OP_BOTH_MIN,
    OP_SLOW
  } mdc_op_t;

  typedef struct packed {
    mdc_op_t op;
    logic    left;
    logic    right;
  } mdc_cmd_t;

endpackage

// File: rtl/mdc_key_decode.sv
// Key decoder for the dual motor duty control.
// Maps a key code, the current mode and the halt flag to a command; uses mdc_pkg.
module mdc_key_decode
  import mdc_pkg::*;
(
  input  logic [7:0] key_code,
  input  logic       dynamic_mode,
  input  logic       halted,
  output mdc_cmd_t   cmd
);

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.left  = 1'b0;
    cmd.right = 1'b0;
    if (halted) begin
      cmd.op = OP_NONE;
    end else if (key_code == KEY_BACKTICK) begin
      cmd.op = OP_HALT;
    end else if (key_code == KEY_TAB) begin
      cmd.op = OP_TOGGLE;
    end else if (dynamic_mode) begin
      unique case (key_code)
        KEY_ARROW_UP: begin
          cmd.op = OP_DYN_FWD; cmd.left = 1'b1; cmd.right = 1'b1;
        end
        KEY_ARROW_DN: begin
          cmd.op = OP_DYN_REV; cmd.left = 1'b1; cmd.right = 1'b1;
        end
        KEY_ARROW_RT: begin
          cmd.op = OP_ACCEL; cmd.right = 1'b1;
        end
        KEY_ARROW_LT: begin
          cmd.op = OP_ACCEL; cmd.left = 1'b1;
        end
        KEY_SPACE: begin
          cmd.op = OP_BOTH_MIN; cmd.left = 1'b1; cmd.right = 1'b1;
        end
        KEY_COMMA, KEY_PERIOD, KEY_ESC, KEY_BRACKET: begin
          cmd.op = OP_NONE;
        end
        default: begin
          cmd.op = OP_SLOW; cmd.left = 1'b1; cmd.right = 1'b1;
        end
      endcase
    end else begin
      unique case (key_code)
        KEY_3: begin cmd.op = OP_SET_MAX;    cmd.left  = 1'b1; end
        KEY_4: begin cmd.op = OP_SET_MAX;    cmd.right = 1'b1; end
        KEY_E: begin cmd.op = OP_ADD_COARSE; cmd.left  = 1'b1; end
        KEY_R: begin cmd.op = OP_ADD_COARSE; cmd.right = 1'b1; end
        KEY_D: begin cmd.op = OP_SUB_COARSE; cmd.left  = 1'b1; end
        KEY_F: begin cmd.op = OP_SUB_COARSE; cmd.right = 1'b1; end
        KEY_C: begin cmd.op = OP_SET_MIN;    cmd.left  = 1'b1; end
        KEY_V: begin cmd.op = OP_SET_MIN;    cmd.right = 1'b1; end
        KEY_W: begin cmd.op = OP_SET_FWD;    cmd.left  = 1'b1; end
        KEY_T: begin cmd.op = OP_SET_FWD;    cmd.right = 1'b1; end
        KEY_S: begin cmd.op = OP_SET_REV;    cmd.left  = 1'b1; end
        KEY_G: begin cmd.op = OP_SET_REV;    cmd.right = 1'b1; end
        default: begin
          cmd.op = OP_NONE;
        end
      endcase
    end
  end

endmodule

// File: rtl/key_driven_dual_motor_duty_control.sv
// Top level of the key driven dual motor duty control.
// Holds the configuration registers, the duty state and the output handshake;
// uses mdc_pkg and mdc_key_decode.
//
// Each beat on the input channel carries one key code and produces exactly one
// result beat that shows both motor duties, the mode and the stop flag after
// that key. The block takes one key per clock cycle unless a result is stalled;
// the result is valid in the cycle after the key is accepted. One decode and one
// saturating add per side sit between the duty registers and their next value,
// and the duty registers drive the result ports directly, so a new key is taken
// whenever the result slot is empty or is being taken in the same cycle.
// Magnitudes are unsigned fixed point with FRAC_BITS fraction bits and one
// integer bit. After the backtick key the block raises stop and ignores every
// further key until reset, while still returning one result beat per key.
module key_driven_dual_motor_duty_control
  import mdc_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             key_code,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   left_reverse,
  output logic [FRAC_BITS:0]     left_level,
  output logic                   right_reverse,
  output logic [FRAC_BITS:0]     right_level,
  output logic                   dynamic_mode,
  output logic                   stop,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [FRAC_BITS:0]     cfg_data
);

  localparam int LW    = FRAC_BITS + 1;
  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam logic [LW-1:0] RST_COARSE = LW'((ONE_Q + 5) / 10);
  localparam logic [LW-1:0] RST_FINE   = LW'((ONE_Q + 10) / 20);
  localparam logic [LW-1:0] RST_BRAKE  = LW'((2 * ONE_Q + 5) / 10);
  localparam logic [LW-1:0] RST_MAX    = LW'(ONE_Q);

  logic [LW-1:0] step_coarse;
  logic [LW-1:0] step_fine;
  logic [LW-1:0] step_brake;
  logic [LW-1:0] duty_min;
  logic [LW-1:0] duty_max;

  logic          left_sign;
  logic          left_sign_next;
  logic [LW-1:0] left_mag;
  logic [LW-1:0] left_mag_next;
  logic          right_sign;
  logic          right_sign_next;
  logic [LW-1:0] right_mag;
  logic [LW-1:0] right_mag_next;
  logic          mode_bit;
  logic          mode_bit_next;
  logic          halted;
  logic          halted_next;

  logic          in_accept;
  mdc_cmd_t      cmd;
  logic signed [LW+1:0] delta;
  logic          left_step;
  logic          right_step;
  logic [LW-1:0] left_sat;
  logic [LW-1:0] right_sat;
  logic          away;

  function automatic logic [LW-1:0] sat_step(
    input logic [LW-1:0]        mag,
    input logic signed [LW+1:0] d,
    input logic [LW-1:0]        lo,
    input logic [LW-1:0]        hi
  );
    logic signed [LW+1:0] s;
    s = $signed({2'b00, mag}) + d;
    if (s >= $signed({2'b00, hi})) begin
      return hi;
    end else if (s <= $signed({2'b00, lo})) begin
      return lo;
    end else begin
      return s[LW-1:0];
    end
  endfunction

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  mdc_key_decode u_decode (
    .key_code     (key_code),
    .dynamic_mode (mode_bit),
    .halted       (halted),
    .cmd          (cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_coarse <= RST_COARSE;
      step_fine   <= RST_FINE;
      step_brake  <= RST_BRAKE;
      duty_min    <= '0;
      duty_max    <= RST_MAX;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEP_COARSE: step_coarse <= cfg_data;
        CFG_STEP_FINE:   step_fine   <= cfg_data;
        CFG_STEP_BRAKE:  step_brake  <= cfg_data;
        CFG_DUTY_MIN:    duty_min    <= cfg_data;
        CFG_DUTY_MAX:    duty_max    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign away = (left_mag != duty_min) | (right_mag != duty_min);

  always_comb begin
    delta      = $signed({2'b00, step_fine});
    left_step  = 1'b0;
    right_step = 1'b0;
    case (cmd.op)
      OP_ADD_COARSE: begin
        delta = $signed({2'b00, step_coarse});
        left_step = cmd.left; right_step = cmd.right;
      end
      OP_SUB_COARSE: begin
        delta = -$signed({2'b00, step_coarse});
        left_step = cmd.left; right_step = cmd.right;
      end
      OP_ACCEL: begin
        delta = $signed({2'b00, step_fine});
        left_step = cmd.left; right_step = cmd.right;
      end
      OP_SLOW: begin
        delta = -$signed({2'b00, step_fine});
        left_step = 1'b1; right_step = 1'b1;
      end
      OP_DYN_FWD: begin
        if (!left_sign && !right_sign) begin
          delta = $signed({2'b00, step_fine});
        end else begin
          delta = -$signed({2'b00, step_brake});
        end
        left_step  = (!left_sign && !right_sign) || away;
        right_step = left_step;
      end
      OP_DYN_REV: begin
        if (left_sign && right_sign) begin
          delta = $signed({2'b00, step_fine});
        end else begin
          delta = -$signed({2'b00, step_brake});
        end
        left_step  = (left_sign && right_sign) || away;
        right_step = left_step;
      end
      default: begin
      end
    endcase
  end

  assign left_sat  = sat_step(left_mag, delta, duty_min, duty_max);
  assign right_sat = sat_step(right_mag, delta, duty_min, duty_max);

  always_comb begin
    left_sign_next  = left_sign;
    right_sign_next = right_sign;
    left_mag_next   = left_step ? left_sat : left_mag;
    right_mag_next  = right_step ? right_sat : right_mag;
    mode_bit_next   = mode_bit;
    halted_next     = halted;
    case (cmd.op)
      OP_HALT:   halted_next   = 1'b1;
      OP_TOGGLE: mode_bit_next = ~mode_bit;
      OP_SET_MAX: begin
        if (cmd.left)  left_mag_next  = duty_max;
        if (cmd.right) right_mag_next = duty_max;
      end
      OP_SET_MIN, OP_BOTH_MIN: begin
        if (cmd.left)  left_mag_next  = duty_min;
        if (cmd.right) right_mag_next = duty_min;
      end
      OP_SET_FWD: begin
        if (cmd.left)  left_sign_next  = 1'b0;
        if (cmd.right) right_sign_next = 1'b0;
      end
      OP_SET_REV: begin
        if (cmd.left)  left_sign_next  = 1'b1;
        if (cmd.right) right_sign_next = 1'b1;
      end
      OP_DYN_FWD: begin
        if ((left_sign || right_sign) && !away) begin
          left_sign_next  = 1'b0;
          right_sign_next = 1'b0;
        end
      end
      OP_DYN_REV: begin
        if (!(left_sign && right_sign) && !away) begin
          left_sign_next  = 1'b1;
          right_sign_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sign  <= 1'b0;
      left_mag   <= '0;
      right_sign <= 1'b0;
      right_mag  <= '0;
      mode_bit   <= 1'b0;
      halted     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept) begin
        left_sign  <= left_sign_next;
        left_mag   <= left_mag_next;
        right_sign <= right_sign_next;
        right_mag  <= right_mag_next;
        mode_bit   <= mode_bit_next;
        halted     <= halted_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  assign left_reverse  = left_sign;
  assign left_level    = left_mag;
  assign right_reverse = right_sign;
  assign right_level   = right_mag;
  assign dynamic_mode  = mode_bit;
  assign stop          = halted;

  // Once halted, the block stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag dropped without reset");

  // Every accepted key leaves a result beat waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted key produced no result beat");

  // The duty state only moves when a key is accepted.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(left_mag) && $stable(right_mag) &&
                   $stable(left_sign) && $stable(right_sign) && $stable(mode_bit))
    else $error("duty state changed without an accepted key");

  // A halted block ignores every key.
  a_halt_freezes: assert property (@(posedge clk) disable iff (rst)
    halted |=> $stable(left_mag) && $stable(right_mag) &&
               $stable(left_sign) && $stable(right_sign) && $stable(mode_bit))
    else $error("state changed while halted");

endmodule
